// File: rtl/dbr_pkg.sv
// Shared types and constants for the button debounce and auto-repeat block.
package dbr_pkg;

    // Width of the button sample, event and level fields
    localparam int KEY_W = 16;
    // Width of the hold and repeat countdowns and of their setting registers
    localparam int CNT_W = 16;
    // Width of the configuration register index
    localparam int CFG_IDX_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 8'd1;

    // Configuration reset values
    localparam logic [CNT_W-1:0] HOLD_DELAY_RESET    = 16'd750;
    localparam logic [CNT_W-1:0] REPEAT_PERIOD_RESET = 16'd100;

    // Parameter defaults
    localparam int HISTORY_DEPTH_DEFAULT = 10;
    localparam int BUTTON_COUNT_DEFAULT  = 16;

    // One result of a tick
    typedef struct packed {
        logic             event_valid;
        logic [KEY_W-1:0] event_mask;
        logic             is_repeat;
        logic [KEY_W-1:0] held_mask;
    } t_result;

endpackage

// File: rtl/dbr_history.sv
// Circular sample history and AND reduction that yields the debounced levels.
module dbr_history #(
    parameter int HISTORY_DEPTH = dbr_pkg::HISTORY_DEPTH_DEFAULT,
    parameter int BUTTON_COUNT  = dbr_pkg::BUTTON_COUNT_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [dbr_pkg::KEY_W-1:0] i_sample,
    output logic [dbr_pkg::KEY_W-1:0] o_levels
);

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam logic [dbr_pkg::KEY_W-1:0] KEY_MASK =
        (BUTTON_COUNT >= dbr_pkg::KEY_W) ? {dbr_pkg::KEY_W{1'b1}} :
        dbr_pkg::KEY_W'((64'd1 << BUTTON_COUNT) - 64'd1);

    logic [dbr_pkg::KEY_W-1:0] r_hist [HISTORY_DEPTH];
    logic [PTR_W-1:0]          r_ptr;
    logic [PTR_W-1:0]          n_ptr;
    logic [dbr_pkg::KEY_W-1:0] w_sample;

    // Drop bits beyond the button count
    assign w_sample = i_sample & KEY_MASK;

    // AND every history word, with the new sample in place of the oldest one
    always_comb begin
        o_levels = KEY_MASK;
        for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (PTR_W'(i) == r_ptr) begin
                o_levels = o_levels & w_sample;
            end else begin
                o_levels = o_levels & r_hist[i];
            end
        end
    end

    // Advance the write pointer with wrap
    always_comb begin
        if (r_ptr == PTR_W'(HISTORY_DEPTH - 1)) begin
            n_ptr = '0;
        end else begin
            n_ptr = r_ptr + PTR_W'(1);
        end
    end

    // Overwrite the oldest sample on each tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
            r_ptr <= '0;
        end else if (i_step) begin
            r_hist[r_ptr] <= w_sample;
            r_ptr         <= n_ptr;
        end
    end

endmodule

// File: rtl/dbr_repeat.sv
// Change detection, hold countdown and auto-repeat countdown for one tick.
module dbr_repeat (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [dbr_pkg::KEY_W-1:0] i_levels,
    input  logic [dbr_pkg::CNT_W-1:0] i_hold_delay,
    input  logic [dbr_pkg::CNT_W-1:0] i_repeat_period,
    output dbr_pkg::t_result          o_result
);

    logic [dbr_pkg::KEY_W-1:0] r_levels;
    logic [dbr_pkg::KEY_W-1:0] r_keys;
    logic [dbr_pkg::CNT_W-1:0] r_hold;
    logic [dbr_pkg::CNT_W-1:0] r_rep;
    logic [dbr_pkg::KEY_W-1:0] n_keys;
    logic [dbr_pkg::CNT_W-1:0] n_hold;
    logic [dbr_pkg::CNT_W-1:0] n_rep;
    logic [dbr_pkg::KEY_W-1:0] w_changed;
    logic [dbr_pkg::KEY_W-1:0] w_fresh;
    logic                      w_fired;

    assign w_changed = r_levels ^ i_levels;
    assign w_fresh   = w_changed & i_levels;

    // Work out the event and the next repeat state
    always_comb begin
        n_keys               = r_keys;
        n_hold               = r_hold;
        n_rep                = r_rep;
        w_fired              = 1'b0;
        o_result.event_valid = 1'b0;
        o_result.event_mask  = '0;
        o_result.is_repeat   = 1'b0;
        o_result.held_mask   = i_levels;
        if (w_changed != '0) begin
            // Report the change; restart repeat unless a newly pressed key is a repeat key
            o_result.event_valid = 1'b1;
            o_result.event_mask  = w_changed;
            if ((w_fresh & r_keys) == '0) begin
                n_keys = w_fresh;
                n_rep  = '0;
                n_hold = (w_fresh != '0) ? i_hold_delay : '0;
            end
        end else begin
            // Count down the hold delay; first repeat when it expires
            if (r_hold != '0) begin
                n_hold = r_hold - dbr_pkg::CNT_W'(1);
                if (r_hold == dbr_pkg::CNT_W'(1)) begin
                    w_fired              = 1'b1;
                    o_result.event_valid = 1'b1;
                    o_result.is_repeat   = 1'b1;
                    o_result.event_mask  = r_keys;
                    n_rep                = i_repeat_period;
                end
            end
            // Count down the repeat period and reload on expiry
            if (!w_fired && r_rep != '0) begin
                if (r_rep == dbr_pkg::CNT_W'(1)) begin
                    o_result.event_valid = 1'b1;
                    o_result.is_repeat   = 1'b1;
                    o_result.event_mask  = r_keys;
                    n_rep                = i_repeat_period;
                end else begin
                    n_rep = r_rep - dbr_pkg::CNT_W'(1);
                end
            end
        end
    end

    // Hold the debounced levels and repeat state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels <= '0;
            r_keys   <= '0;
            r_hold   <= '0;
            r_rep    <= '0;
        end else if (i_step) begin
            r_levels <= i_levels;
            r_keys   <= n_keys;
            r_hold   <= n_hold;
            r_rep    <= n_rep;
        end
    end

endmodule

// File: rtl/button_debounce_autorepeat_top.sv
// Top level of the button debounce and auto-repeat block.
// Each transaction on the input channel is one tick's raw button sample and
// yields exactly one result transaction: the debounced levels, plus a change
// event (mask of changed bits) or a repeat event (held keys) when one occurs.
// The block takes one tick per clock cycle while the result register is free
// or being drained; a tick is held in the input register, and its result then
// in the result register. The AND across the HISTORY_DEPTH-word history and
// the 16-bit countdown update are combinational. Reset clears the history
// and repeat state at once; hold delay (index 0) and repeat period (index 1)
// reset to 750 and 100 and are written through the configuration channel;
// the user must write them only while idle, which the block does not enforce.
module button_debounce_autorepeat_top #(
    parameter int HISTORY_DEPTH = dbr_pkg::HISTORY_DEPTH_DEFAULT,
    parameter int BUTTON_COUNT  = dbr_pkg::BUTTON_COUNT_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dbr_pkg::KEY_W-1:0]     i_raw_buttons,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_event_valid,
    output logic [dbr_pkg::KEY_W-1:0]     o_event_mask,
    output logic                          o_is_repeat,
    output logic [dbr_pkg::KEY_W-1:0]     o_held_mask,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dbr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dbr_pkg::CNT_W-1:0]     i_cfg_data
);

    logic                      r_in_valid;
    logic [dbr_pkg::KEY_W-1:0] r_in_raw;
    logic                      r_out_valid;
    dbr_pkg::t_result          r_out;
    logic [dbr_pkg::CNT_W-1:0] r_hold_delay;
    logic [dbr_pkg::CNT_W-1:0] r_repeat_period;
    logic                      w_move;
    logic [dbr_pkg::KEY_W-1:0] w_levels;
    dbr_pkg::t_result          w_result;

    // Advance a tick when the result register is free or being drained
    assign w_move      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_move;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_delay    <= dbr_pkg::HOLD_DELAY_RESET;
            r_repeat_period <= dbr_pkg::REPEAT_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == dbr_pkg::REG_HOLD_DELAY) begin
                r_hold_delay <= i_cfg_data;
            end
            if (i_cfg_index == dbr_pkg::REG_REPEAT_PERIOD) begin
                r_repeat_period <= i_cfg_data;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_raw <= i_raw_buttons;
        end
    end

    dbr_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .BUTTON_COUNT  (BUTTON_COUNT)
    ) u_history (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_move),
        .i_sample (r_in_raw),
        .o_levels (w_levels)
    );

    dbr_repeat u_repeat (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_move),
        .i_levels        (w_levels),
        .i_hold_delay    (r_hold_delay),
        .i_repeat_period (r_repeat_period),
        .o_result        (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_out.event_valid;
    assign o_event_mask  = r_out.event_mask;
    assign o_is_repeat   = r_out.is_repeat;
    assign o_held_mask   = r_out.held_mask;

`ifndef SYNTHESIS
    // An accepted tick lands in the input register
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_in_valid)
        else $error("accepted tick not held in input register");

    // Every event names at least one button
    a_event_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_valid |-> o_event_mask != '0)
        else $error("event with empty mask");

    // A repeat flag only travels with an event
    a_repeat_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_repeat |-> o_event_valid)
        else $error("repeat flag without event");

    // No event means an empty mask
    a_idle_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_event_valid |-> o_event_mask == '0 && !o_is_repeat)
        else $error("event fields set without event");
`endif

endmodule
